FILE: rtl/dra_pkg.sv
package dra_pkg;

	// Header byte index used for every byte past the fixed 12-byte header.
	localparam logic [3:0] HDR_BODY = 4'd12;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_SHORT     = 4'd1;
	localparam logic [3:0] ST_ID        = 4'd2;
	localparam logic [3:0] ST_FLAGS     = 4'd3;
	localparam logic [3:0] ST_RCODE     = 4'd4;
	localparam logic [3:0] ST_COUNTS    = 4'd5;
	localparam logic [3:0] ST_QUESTION  = 4'd6;
	localparam logic [3:0] ST_NO_ANSWER = 4'd7;
	localparam logic [3:0] ST_NO_A      = 4'd8;
	localparam logic [3:0] ST_RESERVED  = 4'd9;

	localparam logic [7:0] FLAGS_HI     = 8'd129;
	localparam logic [7:0] FLAGS_LO_MSK = 8'd192;
	localparam logic [7:0] FLAGS_LO_VAL = 8'd128;
	localparam logic [7:0] PTR_MARK     = 8'd192;

	typedef enum logic [2:0] {
		PH_LABEL,
		PH_SKIP,
		PH_PTR,
		PH_REC,
		PH_ADDR,
		PH_DONE
	} phase_t;

	// One classified byte passed from the front end to the parser.
	typedef struct packed {
		logic        is_resp;
		logic [3:0]  hdr;
		logic        in_q;
		logic        short_len;
		logic        last;
		logic [7:0]  data;
		logic [15:0] req_id;
		logic [7:0]  qbyte;
	} item_t;

	// Address ranges that are private, reserved or not routable.
	function automatic logic reserved_addr(input logic [31:0] ip);
		logic [7:0] b1, b2, b3;
		b1 = ip[7:0];
		b2 = ip[15:8];
		b3 = ip[23:16];
		return b1 == 8'd0 || b1 == 8'd10
			|| (b1 == 8'd100 && b2 >= 8'd64 && b2 <= 8'd127)
			|| b1 == 8'd127
			|| (b1 == 8'd169 && b2 == 8'd254)
			|| (b1 == 8'd172 && b2 >= 8'd16 && b2 <= 8'd31)
			|| (b1 == 8'd192 && b2 == 8'd0 && b3 == 8'd0)
			|| (b1 == 8'd192 && b2 == 8'd0 && b3 == 8'd2)
			|| (b1 == 8'd192 && b2 == 8'd88 && b3 == 8'd99)
			|| (b1 == 8'd192 && b2 == 8'd168)
			|| (b1 == 8'd198 && b2 >= 8'd18 && b2 <= 8'd19)
			|| (b1 == 8'd198 && b2 == 8'd51 && b3 == 8'd100)
			|| (b1 == 8'd203 && b2 == 8'd0 && b3 == 8'd113)
			|| b1 >= 8'd224;
	endfunction

endpackage

FILE: rtl/dra_ram.sv
module dra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/dra_front.sv
module dra_front import dra_pkg::*; #(
	parameter int QUESTION_MAX = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tlast,
	input  logic        s_tuser,
	output logic        out_valid,
	input  logic        out_ready,
	output item_t       out_item
);

	localparam int AW = $clog2(QUESTION_MAX);
	localparam int LW = $clog2(QUESTION_MAX + 1);

	logic [LW-1:0] qlen_q;
	logic          q_closed_q;
	logic [15:0]   bpos_q;
	logic          v_s1;
	item_t         item_s1;

	logic          accept;
	logic [LW-1:0] wr_idx;
	logic          wr_room;
	logic          wr_en;
	logic [16:0]   qend;
	logic          in_q;
	logic [15:0]   off;
	logic [7:0]    rdata;
	item_t         item_in;

	assign s_tready = !v_s1 || out_ready;
	assign accept   = s_tvalid && s_tready;

	assign wr_idx  = q_closed_q ? '0 : qlen_q;
	assign wr_room = wr_idx < LW'(QUESTION_MAX);
	assign wr_en   = accept && !s_tuser && wr_room;

	assign qend = 17'd12 + 17'(qlen_q);
	assign in_q = bpos_q >= 16'd12 && {1'b0, bpos_q} < qend;
	assign off  = bpos_q - 16'd12;

	dra_ram #(.WIDTH(8), .DEPTH(QUESTION_MAX)) u_qstore (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx[AW-1:0]),
		.wdata (s_tdata[7:0]),
		.re    (accept && s_tuser && in_q),
		.raddr (off[AW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		item_in           = '0;
		item_in.is_resp   = s_tuser;
		item_in.hdr       = (bpos_q < 16'd12) ? bpos_q[3:0] : HDR_BODY;
		item_in.in_q      = in_q;
		item_in.short_len = ({1'b0, bpos_q} + 17'd1) < qend;
		item_in.last      = s_tlast;
		item_in.data      = s_tdata[7:0];
		item_in.req_id    = s_tdata[23:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q     <= '0;
			q_closed_q <= 1'b0;
			bpos_q     <= '0;
		end else if (accept) begin
			if (!s_tuser) begin
				qlen_q     <= wr_room ? wr_idx + LW'(1) : wr_idx;
				q_closed_q <= s_tlast;
				bpos_q     <= '0;
			end else if (s_tlast) begin
				bpos_q <= '0;
			end else if (bpos_q != 16'hFFFF) begin
				bpos_q <= bpos_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	// The store read data stays put until the next read, so it is valid
	// for as long as the registered item waits.
	always_comb begin
		out_item       = item_s1;
		out_item.qbyte = rdata;
	end

	assign out_valid = v_s1;

endmodule

FILE: rtl/dra_fifo.sv
module dra_fifo import dra_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t      ent_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = cnt_q != 3'd4;
	assign pop_valid  = cnt_q != 3'd0;
	assign pop_item   = ent_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 2'd1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(do_push) - 3'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= push_item;
		end
	end

endmodule

FILE: rtl/dra_back.sv
module dra_back import dra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata
);

	logic [3:0]  err_q, n_err;
	phase_t      ph_q, n_ph;
	logic [15:0] skip_q, n_skip;
	logic [3:0]  rfi_q, n_rfi;
	logic [15:0] rlen_q, n_rlen;
	logic [15:0] acnt_q, n_acnt;
	logic [31:0] ttl_q, n_ttl;
	logic [31:0] addr_q, n_addr;
	logic        found_q, n_found;
	logic [3:0]  rc_q, n_rc;
	logic [7:0]  idh_q, n_idh;
	logic        match_q, n_match;

	logic        mv_q;
	logic [71:0] mdata_q;
	logic        pop;
	logic        emit;
	logic [3:0]  status;
	logic [3:0]  rfi_inc;
	logic [7:0]  b;

	assign in_ready = !(in_item.last && in_item.is_resp) || !mv_q || m_tready;
	assign pop      = in_valid && in_ready;
	assign emit     = pop && in_item.is_resp && in_item.last;
	assign b        = in_item.data;
	assign rfi_inc  = rfi_q + 4'd1;

	always_comb begin
		n_err   = err_q;
		n_ph    = ph_q;
		n_skip  = skip_q;
		n_rfi   = rfi_q;
		n_rlen  = rlen_q;
		n_acnt  = acnt_q;
		n_ttl   = ttl_q;
		n_addr  = addr_q;
		n_found = found_q;
		n_rc    = rc_q;
		n_idh   = idh_q;
		n_match = match_q;
		case (in_item.hdr)
			4'd0: begin
				n_idh = in_item.req_id[15:8];
				if (b != in_item.req_id[7:0] && err_q == ST_OK) n_err = ST_ID;
			end
			4'd1: if (b != idh_q && err_q == ST_OK) n_err = ST_ID;
			4'd2: if (b != FLAGS_HI && err_q == ST_OK) n_err = ST_FLAGS;
			4'd3: begin
				n_rc = b[3:0];
				if (err_q == ST_OK) begin
					if ((b & FLAGS_LO_MSK) != FLAGS_LO_VAL) n_err = ST_FLAGS;
					else if (b[3:0] != 4'd0) n_err = ST_RCODE;
				end
			end
			4'd4: if (b != 8'd0 && err_q == ST_OK) n_err = ST_COUNTS;
			4'd5: if (b != 8'd1 && err_q == ST_OK) n_err = ST_COUNTS;
			4'd6: n_acnt = {b, 8'd0};
			4'd7: n_acnt = {acnt_q[15:8], b};
			4'd8, 4'd9, 4'd10, 4'd11: begin
				if (b != 8'd0 && err_q == ST_OK) n_err = ST_COUNTS;
			end
			default: begin
				if (in_item.in_q) begin
					if (b != in_item.qbyte && err_q == ST_OK) n_err = ST_QUESTION;
				end else begin
					case (ph_q)
						PH_LABEL: begin
							if (b == 8'd0) begin
								n_ph = PH_REC; n_rfi = '0; n_match = 1'b1;
								n_rlen = '0; n_ttl = '0;
							end else if ((b & PTR_MARK) == PTR_MARK) begin
								n_ph = PH_PTR;
							end else begin
								n_skip = {8'd0, b};
								n_ph = PH_SKIP;
							end
						end
						PH_PTR: begin
							n_ph = PH_REC; n_rfi = '0; n_match = 1'b1;
							n_rlen = '0; n_ttl = '0;
						end
						PH_SKIP: begin
							if (skip_q != 16'd0) n_skip = skip_q - 16'd1;
							if (skip_q <= 16'd1) n_ph = PH_LABEL;
						end
						PH_REC: begin
							// Type and class must read 0,1,0,1 on the wire.
							if (rfi_q < 4'd4) begin
								if (b != {7'd0, rfi_q[0]}) n_match = 1'b0;
							end else if (rfi_q < 4'd8) begin
								n_ttl = {ttl_q[23:0], b};
							end else begin
								n_rlen = {rlen_q[7:0], b};
							end
							n_rfi = rfi_inc;
							if (rfi_inc >= 4'd10) begin
								if (n_match && n_rlen == 16'd4) begin
									n_ph = PH_ADDR; n_rfi = '0; n_addr = '0;
								end else if (n_rlen == 16'd0) begin
									n_ph = PH_LABEL;
								end else begin
									n_skip = n_rlen;
									n_ph = PH_SKIP;
								end
							end
						end
						PH_ADDR: begin
							case (rfi_q[1:0])
								2'd0: n_addr[7:0]   = b;
								2'd1: n_addr[15:8]  = b;
								2'd2: n_addr[23:16] = b;
								default: n_addr[31:24] = b;
							endcase
							n_rfi = rfi_inc;
							if (rfi_inc >= 4'd4) begin
								n_found = 1'b1;
								n_ph = PH_DONE;
							end
						end
						default: ;
					endcase
				end
			end
		endcase
	end

	always_comb begin
		if (in_item.short_len) status = ST_SHORT;
		else if (n_err != ST_OK) status = n_err;
		else if (n_acnt == 16'd0) status = ST_NO_ANSWER;
		else if (!n_found) status = ST_NO_A;
		else if (reserved_addr(n_addr)) status = ST_RESERVED;
		else status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= '0; ph_q <= PH_LABEL; skip_q <= '0; rfi_q <= '0;
			rlen_q <= '0; acnt_q <= '0; ttl_q <= '0; addr_q <= '0;
			found_q <= 1'b0; rc_q <= '0; idh_q <= '0; match_q <= 1'b0;
		end else if (pop) begin
			if (!in_item.is_resp || in_item.last) begin
				err_q <= '0; ph_q <= PH_LABEL; skip_q <= '0; rfi_q <= '0;
				rlen_q <= '0; acnt_q <= '0; ttl_q <= '0; addr_q <= '0;
				found_q <= 1'b0; rc_q <= '0; idh_q <= '0; match_q <= 1'b0;
			end else begin
				err_q <= n_err; ph_q <= n_ph; skip_q <= n_skip; rfi_q <= n_rfi;
				rlen_q <= n_rlen; acnt_q <= n_acnt; ttl_q <= n_ttl;
				addr_q <= n_addr; found_q <= n_found; rc_q <= n_rc;
				idh_q <= n_idh; match_q <= n_match;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (emit) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			mdata_q <= {n_rc, status,
				(status == ST_OK) ? n_ttl : 32'd0,
				(status == ST_OK) ? n_addr : 32'd0};
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = mdata_q;

endmodule

FILE: rtl/dns_response_a_record_extractor.sv
// DNS response A-record extractor.
// The slave channel carries one byte per request. tuser = 0 marks a byte of
// the question that was sent, which is kept in an on-chip store; tlast on a
// question byte closes it, and the next question byte starts a new one.
// tuser = 1 marks a response byte; tdata[23:8] carries the expected
// transaction id, sampled with response byte 0. The front end counts
// positions and reads the stored question byte for each echoed question
// byte; the back end checks the header and walks the answer records.
// On the response byte with tlast the master channel delivers one request:
// address, TTL, status and the header RCODE.
// Throughput is one byte per cycle while the master side does not stall,
// set by the single store read port and the one-byte parser step. The last
// byte is loaded into the front stage, then written into the queue, and its
// pop loads the output register, which presents the result.
// A four-entry queue separates the two halves, so a stalled master side
// only holds the parser once a result is waiting; input keeps flowing
// until the queue fills. Reset clears all control state and the question
// length; no clearing pass is needed.
module dns_response_a_record_extractor import dra_pkg::*; #(
	parameter int QUESTION_MAX = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data[7:0], req_id[23:8]
	input  logic        s_tlast,   // last byte of question or response
	input  logic        s_tuser,   // func: 0 question byte, 1 response byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // address[31:0], ttl[63:32], status[67:64], rcode[71:68]
);

	logic  f_valid;
	logic  f_ready;
	item_t f_item;
	logic  b_valid;
	logic  b_ready;
	item_t b_item;

	dra_front #(.QUESTION_MAX(QUESTION_MAX)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_item  (f_item)
	);

	dra_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	dra_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (b_valid),
		.in_ready (b_ready),
		.in_item  (b_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: rtl/dra_checker.sv
module dra_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	// A result waiting on the receiver must hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[67:64] <= 4'd9)
		else $error("status out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[67:64] != 4'd0 |-> m_tdata[63:0] == 64'd0)
		else $error("address or ttl set on a failed response");

	// A good address always has a nonzero first octet below 224.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[67:64] == 4'd0
		|-> m_tdata[7:0] != 8'd0 && m_tdata[7:0] < 8'd224)
		else $error("reserved address reported as ok");

endmodule

bind dns_response_a_record_extractor dra_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
